FILE: rtl/core/mat3i_pkg.sv
// Shared constants for the 3x3 matrix inverse: counts and the operand
// index tables of adjugate cofactors and determinant. No dependencies.
package mat3i_pkg;

    localparam int unsigned N_ELEM = 9;
    localparam int unsigned N_DET  = 3;

    // Cofactor e = a[P]*a[Q] - a[R]*a[S], elements numbered 3*row+col
    localparam int unsigned CF_P [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned CF_Q [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned CF_R [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned CF_S [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // Determinant: a[0]*c[0] + a[1]*c[3] + a[2]*c[6]
    localparam int unsigned DET_C [N_DET] = '{0, 3, 6};

endpackage

FILE: rtl/core/matrix3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse: a fully pipelined
// adjugate / determinant datapath with a restoring divider, one bit a stage.
// Depends on mat3i_pkg.
//
// Usage
//   Slave channel: one item is a whole matrix, nine signed elements of
//   ELEM_WIDTH bits with FRAC_BITS fraction bits, packed a00 lowest up to a22.
//   Master channel: one item is the inverse, b00 lowest up to b22, with the
//   singular flag in tuser bit 0 and the saturated flag in tuser bit 1.
//   Throughput: one matrix per cycle, sustained with no gaps while results are accepted.
//   Pipeline: six arithmetic stages, ELEM_WIDTH divider stages and the output
//   register lie between acceptance and tvalid. The depth is set mostly by the
//   divider, which resolves one quotient bit of all nine elements in each stage.
//   Reset clears every valid bit; the payload registers are left as they are.
//   Stall: while a result waits unaccepted, the whole pipeline holds and the
//   slave tready drops; nothing is lost or repeated, and items further back
//   keep their places.
//   A zero determinant gives all-zero elements with singular set; a quotient
//   outside the element range is clamped and raises saturated.
module matrix3_inverse #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 from the lowest bit up
    input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0]   i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // b00, b01, b02, b10, b11, b12, b20, b21, b22 from the lowest bit up
    output logic [((9*ELEM_WIDTH+7)/8)*8-1:0]   o_m_axis_tdata,
    // singular, saturated from the lowest bit up
    output logic [1:0]                          o_m_axis_tuser
);
    import mat3i_pkg::*;

    localparam int W    = ELEM_WIDTH;
    localparam int TDW  = ((9*ELEM_WIDTH+7)/8)*8;
    localparam int PW   = 2*W;            // element product
    localparam int CW   = 2*W + 1;        // cofactor
    localparam int HW   = 2*W + 1;        // determinant partial product
    localparam int DW   = 3*W + 3;        // determinant
    localparam int NW   = CW + 2*FRAC_BITS;
    localparam int RW   = ((NW > DW + W) ? NW : DW + W) + 1;

    // Advance the whole pipeline unless a finished result is stalled
    logic en;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    logic signed [W-1:0] a_in [N_ELEM];
    always_comb begin
        for (int e = 0; e < N_ELEM; e++) begin
            a_in[e] = i_s_axis_tdata[e*W +: W];
        end
    end

    // Stage 1: the eighteen element products
    logic                 r_v1;
    logic signed [PW-1:0] r_pl [N_ELEM];
    logic signed [PW-1:0] r_pr [N_ELEM];
    logic signed [W-1:0]  r_a1 [N_DET];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
        end
        if (en) begin
            for (int e = 0; e < N_ELEM; e++) begin
                r_pl[e] <= a_in[CF_P[e]] * a_in[CF_Q[e]];
                r_pr[e] <= a_in[CF_R[e]] * a_in[CF_S[e]];
            end
            for (int k = 0; k < N_DET; k++) begin
                r_a1[k] <= a_in[k];
            end
        end
    end

    // Stage 2: cofactors
    logic                 r_v2;
    logic signed [CW-1:0] r_c2 [N_ELEM];
    logic signed [W-1:0]  r_a2 [N_DET];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            for (int e = 0; e < N_ELEM; e++) begin
                r_c2[e] <= CW'(r_pl[e]) - CW'(r_pr[e]);
            end
            r_a2 <= r_a1;
        end
    end

    // Stage 3: determinant partial products, cofactor split into low and high halves
    logic                 r_v3;
    logic signed [CW-1:0] r_c3 [N_ELEM];
    logic signed [HW-1:0] r_dlo [N_DET];
    logic signed [HW-1:0] r_dhi [N_DET];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
        if (en) begin
            for (int k = 0; k < N_DET; k++) begin
                r_dlo[k] <= r_a2[k] * $signed({1'b0, r_c2[DET_C[k]][W-1:0]});
                r_dhi[k] <= r_a2[k] * $signed(r_c2[DET_C[k]][CW-1:W]);
            end
            r_c3 <= r_c2;
        end
    end

    // Stage 4: determinant
    logic                 r_v4;
    logic signed [CW-1:0] r_c4 [N_ELEM];
    logic signed [DW-1:0] r_det;
    logic signed [DW-1:0] n_det;

    always_comb begin
        n_det = '0;
        for (int k = 0; k < N_DET; k++) begin
            n_det = n_det + (DW'(r_dhi[k]) <<< W) + DW'(r_dlo[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
        if (en) begin
            r_det <= n_det;
            r_c4  <= r_c3;
        end
    end

    // Stage 5: magnitudes and result signs
    logic          r_v5;
    logic [CW-1:0] r_mc5 [N_ELEM];
    logic          r_neg5 [N_ELEM];
    logic [DW-1:0] r_md5;
    logic          r_sing5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= r_v4;
        end
        if (en) begin
            for (int e = 0; e < N_ELEM; e++) begin
                r_mc5[e]  <= r_c4[e][CW-1] ? CW'(-r_c4[e]) : CW'(r_c4[e]);
                r_neg5[e] <= r_c4[e][CW-1] ^ r_det[DW-1];
            end
            r_md5   <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
            r_sing5 <= (r_det == '0);
        end
    end

    // Stage 6 (divider entry): scale numerator, flag quotients of 2^W or more
    logic          r_vd   [W+1];
    logic [RW-1:0] r_rem  [W+1][N_ELEM];
    logic [W-1:0]  r_q    [W+1][N_ELEM];
    logic          r_neg  [W+1][N_ELEM];
    logic          r_ovf  [W+1][N_ELEM];
    logic [DW-1:0] r_md   [W+1];
    logic          r_sing [W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else if (en) begin
            r_vd[0] <= r_v5;
        end
        if (en) begin
            for (int e = 0; e < N_ELEM; e++) begin
                r_rem[0][e] <= RW'(r_mc5[e]) << (2*FRAC_BITS);
                r_ovf[0][e] <= (RW'(r_mc5[e]) << (2*FRAC_BITS)) >= (RW'(r_md5) << W);
                r_q[0][e]   <= '0;
                r_neg[0][e] <= r_neg5[e];
            end
            r_md[0]   <= r_md5;
            r_sing[0] <= r_sing5;
        end
    end

    // Divider stages: stage j settles quotient bit W-1-j of all nine elements
    for (genvar j = 0; j < W; j++) begin : g_div
        localparam int SH = W - 1 - j;
        logic [RW-1:0] dsh;
        assign dsh = RW'(r_md[j]) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[j+1] <= 1'b0;
            end else if (en) begin
                r_vd[j+1] <= r_vd[j];
            end
            if (en) begin
                for (int e = 0; e < N_ELEM; e++) begin
                    if (r_rem[j][e] >= dsh) begin
                        r_rem[j+1][e] <= r_rem[j][e] - dsh;
                        r_q[j+1][e]   <= r_q[j][e] | (W'(1) << SH);
                    end else begin
                        r_rem[j+1][e] <= r_rem[j][e];
                        r_q[j+1][e]   <= r_q[j][e];
                    end
                    r_neg[j+1][e] <= r_neg[j][e];
                    r_ovf[j+1][e] <= r_ovf[j][e];
                end
                r_md[j+1]   <= r_md[j];
                r_sing[j+1] <= r_sing[j];
            end
        end
    end

    // Output stage: clamp, apply sign, zero everything on a singular matrix
    logic [W-1:0]   n_b [N_ELEM];
    logic [N_ELEM-1:0] n_sat;
    logic [W-1:0]   lim_pos;
    logic [W-1:0]   lim_neg;

    assign lim_pos = {1'b0, {(W-1){1'b1}}};
    assign lim_neg = {1'b1, {(W-1){1'b0}}};

    always_comb begin
        for (int e = 0; e < N_ELEM; e++) begin
            n_sat[e] = 1'b0;
            n_b[e]   = '0;
            if (!r_sing[W]) begin
                if (r_neg[W][e]) begin
                    if (r_ovf[W][e] || r_q[W][e] > lim_neg) begin
                        n_sat[e] = 1'b1;
                        n_b[e]   = lim_neg;
                    end else begin
                        n_b[e] = W'(-r_q[W][e]);
                    end
                end else begin
                    if (r_ovf[W][e] || r_q[W][e] > lim_pos) begin
                        n_sat[e] = 1'b1;
                        n_b[e]   = lim_pos;
                    end else begin
                        n_b[e] = r_q[W][e];
                    end
                end
            end
        end
    end

    logic [TDW-1:0] n_tdata;
    always_comb begin
        n_tdata = '0;
        for (int e = 0; e < N_ELEM; e++) begin
            n_tdata[e*W +: W] = n_b[e];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_axis_tvalid <= 1'b0;
        end else if (en) begin
            o_m_axis_tvalid <= r_vd[W];
        end
        if (en) begin
            o_m_axis_tdata <= n_tdata;
            o_m_axis_tuser <= {(|n_sat) & ~r_sing[W], r_sing[W]};
        end
    end

endmodule
